// ===== sv/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_ESC   = 3'd1;
	localparam logic [2:0] ST_BAD_HEX   = 3'd2;
	localparam logic [2:0] ST_SURROGATE = 3'd3;
	localparam logic [2:0] ST_ZERO_CP   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;
	localparam logic [2:0] ST_TRUNC     = 3'd6;

	localparam logic [0:0] REG_CAPACITY   = 1'd0;
	localparam logic [0:0] REG_COUNT_ONLY = 1'd1;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;
	localparam logic [20:0] MAX_1B      = 21'h7F;
	localparam logic [20:0] MAX_2B      = 21'h7FF;
	localparam logic [20:0] MAX_3B      = 21'hFFFF;

	typedef struct packed {
		logic        ok;
		logic [3:0]  value;
	} nibble_t;

	typedef struct packed {
		logic [1:0]  pad;
		logic [15:0] total_len;
		logic [2:0]  status;
		logic [2:0]  out_count;
		logic [31:0] out_bytes;
	} result_t;

	function automatic nibble_t hex_nibble(input logic [7:0] b);
		nibble_t r;
		r.ok = 1'b1;
		r.value = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.value = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r.value = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r.value = 4'(b - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/json_string_unescape_utf8.sv =====
`default_nettype none

// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: in_byte; tuser: has_byte; tlast: last_byte
// m_axis    out  m_axis_tvalid/tready        tdata: out_bytes, out_count, status, total_len;
//                                            tlast: string_done
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// One byte per cycle: an input register, then the escape decode, UTF-8 encode and
// length check in one combinational pass into the result register. Output stalls
// back-pressure the input register; a new byte is taken whenever the result
// register empties in the same cycle. Reset clears the escape state, the sticky
// error and the counter; capacity resets to 65535.

module json_string_unescape_utf8 #(
	parameter int LENGTH_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  wire         s_axis_tuser,   // [0] has_byte
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [31:0] out_bytes, [34:32] out_count,
	                                    // [37:35] status, [53:38] total_len
	output logic        m_axis_tlast,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [0:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	localparam int CW = (LENGTH_BITS + 1 > 17) ? LENGTH_BITS + 1 : 17;

	localparam logic [3:0] PH_PLAIN  = 4'd0;
	localparam logic [3:0] PH_ESC    = 4'd1;
	localparam logic [3:0] PH_HI0    = 4'd2;
	localparam logic [3:0] PH_HI3    = 4'd5;
	localparam logic [3:0] PH_WANT_BS = 4'd6;
	localparam logic [3:0] PH_WANT_U = 4'd7;
	localparam logic [3:0] PH_LO0    = 4'd8;
	localparam logic [3:0] PH_LO3    = 4'd11;

	logic [15:0]            cap_q;
	logic                   count_only_q;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   has_s1;
	logic                   last_s1;

	logic                   valid_s2;
	jsu_pkg::result_t       res_s2;
	logic                   last_s2;

	logic [3:0]             phase_q;
	logic [15:0]            hi_q;
	logic [15:0]            lo_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [2:0]             err_q;

	logic [3:0]             phase_n;
	logic [15:0]            hi_n;
	logic [15:0]            lo_n;
	logic [LENGTH_BITS-1:0] len_n;
	logic [2:0]             err_n;

	logic                   out_free;
	logic                   adv;

	jsu_pkg::nibble_t       nib;
	logic                   emit_en;
	logic [7:0]             emit_byte;
	logic                   cp_en;
	logic [20:0]            cp;
	logic [31:0]            pk;
	logic [2:0]             pk_n;
	logic [LENGTH_BITS:0]   len_sum;
	logic [CW-1:0]          sum_ext;
	logic [CW-1:0]          cap_ext;
	logic [31:0]            bytes_c;
	logic [2:0]             count_c;
	logic [LENGTH_BITS+15:0] len_wide;
	jsu_pkg::result_t       res_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 16'hFFFF;
			count_only_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jsu_pkg::REG_CAPACITY: cap_q <= cfg_data;
				jsu_pkg::REG_COUNT_ONLY: count_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free = !valid_s2 || m_axis_tready;
	assign adv = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			has_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	assign nib = jsu_pkg::hex_nibble(byte_s1);

	always_comb begin
		phase_n = phase_q;
		hi_n = hi_q;
		lo_n = lo_q;
		err_n = err_q;
		emit_en = 1'b0;
		emit_byte = byte_s1;
		cp_en = 1'b0;
		cp = 21'd0;
		if (has_s1 && err_q == jsu_pkg::ST_OK) begin
			if (phase_q == PH_ESC) begin
				phase_n = PH_PLAIN;
				case (byte_s1)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
						emit_en = 1'b1;
					end
					jsu_pkg::CH_B: begin
						emit_en = 1'b1;
						emit_byte = jsu_pkg::CTL_BS;
					end
					jsu_pkg::CH_F: begin
						emit_en = 1'b1;
						emit_byte = jsu_pkg::CTL_FF;
					end
					jsu_pkg::CH_N: begin
						emit_en = 1'b1;
						emit_byte = jsu_pkg::CTL_LF;
					end
					jsu_pkg::CH_R: begin
						emit_en = 1'b1;
						emit_byte = jsu_pkg::CTL_CR;
					end
					jsu_pkg::CH_T: begin
						emit_en = 1'b1;
						emit_byte = jsu_pkg::CTL_HT;
					end
					jsu_pkg::CH_U: begin
						phase_n = PH_HI0;
						hi_n = 16'd0;
					end
					default: err_n = jsu_pkg::ST_BAD_ESC;
				endcase
			end else if (phase_q >= PH_HI0 && phase_q <= PH_HI3) begin
				if (!nib.ok) begin
					err_n = jsu_pkg::ST_BAD_HEX;
					phase_n = PH_PLAIN;
				end else begin
					hi_n = {hi_q[11:0], nib.value};
					if (phase_q != PH_HI3) begin
						phase_n = phase_q + 4'd1;
					end else if (hi_n >= jsu_pkg::HI_SURR_MIN && hi_n <= jsu_pkg::HI_SURR_MAX) begin
						phase_n = PH_WANT_BS;
					end else if (hi_n >= jsu_pkg::LO_SURR_MIN && hi_n <= jsu_pkg::LO_SURR_MAX) begin
						phase_n = PH_PLAIN;
						err_n = jsu_pkg::ST_SURROGATE;
					end else begin
						phase_n = PH_PLAIN;
						cp_en = 1'b1;
						cp = {5'd0, hi_n};
					end
				end
			end else if (phase_q == PH_WANT_BS) begin
				if (byte_s1 == jsu_pkg::CH_BSLASH) begin
					phase_n = PH_WANT_U;
				end else begin
					phase_n = PH_PLAIN;
					err_n = jsu_pkg::ST_SURROGATE;
				end
			end else if (phase_q == PH_WANT_U) begin
				if (byte_s1 == jsu_pkg::CH_U) begin
					phase_n = PH_LO0;
					lo_n = 16'd0;
				end else begin
					phase_n = PH_PLAIN;
					err_n = jsu_pkg::ST_SURROGATE;
				end
			end else if (phase_q >= PH_LO0 && phase_q <= PH_LO3) begin
				if (!nib.ok) begin
					err_n = jsu_pkg::ST_BAD_HEX;
					phase_n = PH_PLAIN;
				end else begin
					lo_n = {lo_q[11:0], nib.value};
					if (phase_q != PH_LO3) begin
						phase_n = phase_q + 4'd1;
					end else begin
						phase_n = PH_PLAIN;
						if (lo_n < jsu_pkg::LO_SURR_MIN || lo_n > jsu_pkg::LO_SURR_MAX) begin
							err_n = jsu_pkg::ST_SURROGATE;
						end else begin
							cp_en = 1'b1;
							cp = jsu_pkg::SUPP_BASE + {1'b0, hi_q[9:0], lo_n[9:0]};
						end
					end
				end
			end else begin
				phase_n = PH_PLAIN;
				if (byte_s1 == jsu_pkg::CH_BSLASH) begin
					phase_n = PH_ESC;
				end else begin
					emit_en = 1'b1;
				end
			end
		end

		pk = {24'd0, emit_byte};
		pk_n = 3'd1;
		if (cp_en) begin
			if (cp <= jsu_pkg::MAX_1B) begin
				pk = {24'd0, cp[7:0]};
				pk_n = 3'd1;
			end else if (cp <= jsu_pkg::MAX_2B) begin
				pk = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
				pk_n = 3'd2;
			end else if (cp <= jsu_pkg::MAX_3B) begin
				pk = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
				pk_n = 3'd3;
			end else begin
				pk = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
				pk_n = 3'd4;
			end
			if (cp == 21'd0) begin
				err_n = jsu_pkg::ST_ZERO_CP;
			end else begin
				emit_en = 1'b1;
			end
		end

		len_n = len_q;
		bytes_c = 32'd0;
		count_c = 3'd0;
		len_sum = {1'b0, len_q} + (LENGTH_BITS + 1)'(pk_n);
		sum_ext = CW'(len_sum);
		cap_ext = CW'(cap_q);
		if (emit_en) begin
			if (len_sum[LENGTH_BITS]) begin
				err_n = jsu_pkg::ST_FULL;
			end else if (!count_only_q && sum_ext >= cap_ext) begin
				err_n = jsu_pkg::ST_FULL;
			end else begin
				len_n = len_sum[LENGTH_BITS-1:0];
				bytes_c = pk;
				count_c = pk_n;
			end
		end
		if (err_n != jsu_pkg::ST_OK) begin
			bytes_c = 32'd0;
			count_c = 3'd0;
		end
		if (last_s1 && err_n == jsu_pkg::ST_OK) begin
			if (phase_n != PH_PLAIN) begin
				err_n = jsu_pkg::ST_TRUNC;
			end else if (!count_only_q && cap_q == 16'd0) begin
				err_n = jsu_pkg::ST_FULL;
			end
		end

		len_wide = {16'd0, len_n};
		res_c.pad = 2'd0;
		res_c.total_len = len_wide[15:0];
		res_c.status = err_n;
		res_c.out_count = count_c;
		res_c.out_bytes = bytes_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			hi_q <= 16'd0;
			lo_q <= 16'd0;
			len_q <= '0;
			err_q <= jsu_pkg::ST_OK;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= PH_PLAIN;
				hi_q <= 16'd0;
				lo_q <= 16'd0;
				len_q <= '0;
				err_q <= jsu_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				hi_q <= hi_n;
				lo_q <= lo_n;
				len_q <= len_n;
				err_q <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
			last_s2 <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = res_s2;
	assign m_axis_tlast = last_s2;

endmodule

`default_nettype wire
